// File: design/pidc_pkg.sv
package pidc_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

    // Request op codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Smallest period, 0.0001 s in Q8.24
    localparam logic [31:0] DT_FLOOR = 32'd1678;

    // Divider numerator: 33 bit error difference magnitude times 2^24
    localparam int DIV_FRAC_W = 24;
    localparam int DIV_NUM_W  = 33 + DIV_FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INT,
        ST_ACC,
        ST_MUL_I,
        ST_ADD_I,
        ST_DIV_WAIT,
        ST_MUL_D,
        ST_ADD_D,
        ST_WRITE
    } pidc_state_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [32:0] mag;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/pidc_mul.sv
module pidc_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);
    import pidc_pkg::*;

    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: design/pidc_div.sv
module pidc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pidc_pkg::div_req_t  req,
    output pidc_pkg::div_stat_t stat,
    output logic signed [31:0]  quot
);
    import pidc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [31:0]          den_reg;
    logic                 neg_reg;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic        fits;
    logic        over;

    // One restoring step a cycle: numerator bits leave the top of quo_reg,
    // quotient bits enter at the bottom.
    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = {req.mag, {DIV_FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[31:0] : shifted[31:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
            neg_reg <= req.neg;
        end
    end

    // Apply the sign and saturate the magnitude to 32 bits
    always_comb
    begin
        if (neg_reg)
        begin
            over = (|quo_reg[DIV_NUM_W-1:32]) || (quo_reg[31] && (|quo_reg[30:0]));
            quot = over ? 32'sh8000_0000 : $signed(32'(32'd0 - quo_reg[31:0]));
        end
        else
        begin
            over = |quo_reg[DIV_NUM_W-1:31];
            quot = over ? 32'sh7FFF_FFFF : $signed(quo_reg[31:0]);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/pid_controller_clamped.sv
// PID step with integral clamp, one request at a time, one shared 33x33 multiplier.
// A clear request goes straight to the write state. An update steps through the
// multiply and add states and, except on the first sample after a clear or reset,
// waits for the 57 step serial divider forming the derivative. in_stall stays high
// until the result loads: a new request is taken the cycle after, at the earliest.
// Reset (rst_n low, async): gains, limits, integral, last error clear to zero.
module pid_controller_clamped (
    input  logic                           clk,
    input  logic                           rst_n,
    // input requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic signed [31:0]             err_in,
    input  logic [31:0]                    period,
    // results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             drive,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import pidc_pkg::*;

    pidc_state_t state_reg, state_next;

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        out_limit_reg, integ_limit_reg;

    // controller history
    logic signed [31:0] integ_acc_reg, integ_next;
    logic signed [31:0] last_err_reg;
    logic               have_last_reg;

    // per request working registers
    logic signed [31:0] e_reg;
    logic [31:0]        dt_reg;
    logic               use_deriv_reg;
    logic signed [31:0] deriv_reg;
    logic signed [49:0] sum_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] drive_reg;

    logic               in_fire;
    logic               out_load;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [47:0] term;
    logic signed [49:0] term_ext;

    // divider
    div_req_t           div_req;
    div_stat_t          div_stat;
    logic signed [31:0] div_quot;
    logic signed [32:0] err_diff;
    logic               div_start;

    // integral update
    logic signed [39:0] integ_step;
    logic signed [40:0] integ_sum;
    logic signed [40:0] integ_lim;

    // output clamp
    logic signed [49:0] out_lim;
    logic signed [31:0] drive_next;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_WRITE) && (!out_valid_reg || !out_stall);

    pidc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign err_diff      = {e_reg[31], e_reg} - {last_err_reg[31], last_err_reg};
    assign div_req.start = div_start;
    assign div_req.neg   = err_diff[32];
    assign div_req.mag   = err_diff[32] ? 33'(33'd0 - err_diff) : err_diff;
    assign div_req.den   = dt_reg;

    pidc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Product scaled back by 16 (floor), as a summand
    assign term     = prod[63:16];
    assign term_ext = {{2{term[47]}}, term};

    // Integral: add err*dt scaled by 24 (floor), clamp to the integral limit
    assign integ_step = prod[63:24];
    assign integ_sum  = {{9{integ_acc_reg[31]}}, integ_acc_reg} + {integ_step[39], integ_step};
    assign integ_lim  = $signed({10'd0, integ_limit_reg});

    always_comb
    begin
        if (integ_sum > integ_lim)
            integ_next = integ_lim[31:0];
        else if (integ_sum < -integ_lim)
            integ_next = 32'(-integ_lim);
        else
            integ_next = integ_sum[31:0];
    end

    // Saturate the summed terms to the output limit
    assign out_lim = $signed({19'd0, out_limit_reg});

    always_comb
    begin
        if (sum_reg > out_lim)
            drive_next = out_lim[31:0];
        else if (sum_reg < -out_lim)
            drive_next = 32'(-out_lim);
        else
            drive_next = sum_reg[31:0];
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (op == OP_CLEAR) ? ST_WRITE : ST_MUL_INT;
            end
            ST_MUL_INT:  state_next = ST_ACC;
            ST_ACC:      state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_ADD_I;
            ST_ADD_I:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!use_deriv_reg || div_stat.done)
                    state_next = ST_MUL_D;
            end
            ST_MUL_D:    state_next = ST_ADD_D;
            ST_ADD_D:    state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs (multiplier operands, divider start, input stall)
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        in_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MUL_INT:
            begin
                mul_a = {e_reg[31], e_reg};
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_ACC:
            begin
                mul_a     = {gain_p_reg[31], gain_p_reg};
                mul_b     = {e_reg[31], e_reg};
                div_start = have_last_reg;
            end
            ST_MUL_I:
            begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {integ_acc_reg[31], integ_acc_reg};
            end
            ST_MUL_D:
            begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = {deriv_reg[31], deriv_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            out_limit_reg   <= '0;
            integ_limit_reg <= '0;
            integ_acc_reg   <= '0;
            last_err_reg    <= '0;
            have_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // hold the result until taken; drop valid once taken
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // register writes; ignore indexes beyond the list
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:      gain_p_reg      <= cfg_data;
                    REG_GAIN_I:      gain_i_reg      <= cfg_data;
                    REG_GAIN_D:      gain_d_reg      <= cfg_data;
                    REG_OUT_LIMIT:   out_limit_reg   <= cfg_data[30:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[30:0];
                    default:         gain_p_reg      <= gain_p_reg;
                endcase
            end

            // clear the history on a clear request
            if (in_fire && (op == OP_CLEAR))
            begin
                integ_acc_reg <= '0;
                last_err_reg  <= '0;
                have_last_reg <= 1'b0;
            end
            else if (state_reg == ST_ACC)
            begin
                integ_acc_reg <= integ_next;
                last_err_reg  <= e_reg;
                have_last_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_reg         <= err_in;
            dt_reg        <= (period <= DT_FLOOR) ? DT_FLOOR : period;
            use_deriv_reg <= have_last_reg && (op == OP_UPDATE);
            sum_reg       <= '0;
        end
        case (state_reg)
            ST_MUL_I:    sum_reg <= term_ext;
            ST_ADD_I:    sum_reg <= sum_reg + term_ext;
            ST_ADD_D:    sum_reg <= sum_reg + term_ext;
            ST_DIV_WAIT: deriv_reg <= use_deriv_reg ? div_quot : 32'sd0;
            default:     deriv_reg <= deriv_reg;
        endcase
        if (out_load)
            drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // A fresh result only comes from the write state
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside the write state");

    // The divider runs only from the integral multiply through the divider wait state
    a_div_busy_window: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_MUL_I || state_reg == ST_ADD_I ||
                           state_reg == ST_DIV_WAIT))
        else $error("divider busy outside its window");

    // No derivative on the first sample after a clear
    a_first_deriv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_D && !use_deriv_reg) |-> (deriv_reg == 32'sd0))
        else $error("derivative nonzero on first sample");

    // A clear request empties the history
    a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == OP_CLEAR) |=> (!have_last_reg && integ_acc_reg == 32'sd0 &&
                                        last_err_reg == 32'sd0))
        else $error("history not cleared");

endmodule
